/* hw/rtl/crcc_pkg.sv */
// ----------------------------------------------------------------------------
// crcc_pkg: shared types and constants of the copy range cover checker
// Function codes, status codes and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package crcc_pkg;

   localparam int MAX_DESTS_DEF  = 16;
   localparam int MAX_RANGES_DEF = 64;

   localparam int FUNC_W   = 2;
   localparam int IDX_W    = 4;
   localparam int DATA_W   = 64;
   localparam int STATUS_W = 3;
   localparam int DCNT_W   = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_COUNT  = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_RANGE  = 2'd1,
      FUNC_FINISH = 2'd2,
      FUNC_RSVD   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NO_RANGES = 3'd1,
      STAT_BAD_INDEX = 3'd2,
      STAT_ZERO_LEN  = 3'd3,
      STAT_OVERFLOW  = 3'd4,
      STAT_OOB       = 3'd5,
      STAT_BAD_COVER = 3'd6,
      STAT_FULL      = 3'd7
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       accept_simple;  // load size or reserved code
      logic       accept_range;   // capture range operands
      logic       range_done;     // finish range checks
      logic       fin_quick;      // finish with no cover scan
      logic       scan_init;      // start cover scan
      logic       scan_step;      // evaluate one stored range
      logic       dest_next;      // advance to next destination
      logic       fin_emit;       // emit cover scan result
      status_type fin_code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_free;
      logic fin_quick;
      logic match;
      logic last_k;
      logic size_ok;
      logic last_dest;
      logic all_used;
   } sts_type;

endpackage

/* hw/rtl/copy_range_cover_checker.sv */
// ----------------------------------------------------------------------------
// copy_range_cover_checker: copy descriptor range and cover checker
// Checks copy ranges against source and destination sizes and, on finish,
// confirms each destination is covered exactly.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write source_size (index 0) and dest_count (index 1) while idle.
//   req_*  : one item per transfer; func selects load size, add range or
//            finish. Every item gives exactly one rsp_* transfer.
//   rsp_*  : status and final_res, held in an output register until taken.
// Sequence: a load size item answers in the cycle after transfer; a range item
//   passes the operand register stage and the second check stage first. A
//   finish item with a latched error, an empty store or no active destination
//   answers in the cycle after transfer; otherwise the cover scan runs over the
//   store, whose single read port sets the cost: each stored range visited
//   takes a read and a compare state, every range is revisited after each
//   match, and a full pass with no match closes each destination, plus a read and a compare state per destination.
// Throughput: one item at a time; a new item is taken once the previous one
//   has produced its result and the output register is free or being taken.
// Reset: clears control state, the range count and the latched error;
//   source_size returns to 0, dest_count to 1. Size table and store contents
//   are undefined until written. A stalled receiver holds the result and
//   blocks further requests.
// ----------------------------------------------------------------------------
module copy_range_cover_checker #(
   parameter int MAX_DESTS  = crcc_pkg::MAX_DESTS_DEF,
   parameter int MAX_RANGES = crcc_pkg::MAX_RANGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [crcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [crcc_pkg::DATA_W-1:0]           csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [crcc_pkg::FUNC_W-1:0]           req_func,
   input  logic [crcc_pkg::IDX_W-1:0]            req_dest_index,
   input  logic [crcc_pkg::DATA_W-1:0]           req_dest_size,
   input  logic [crcc_pkg::DATA_W-1:0]           req_length,
   input  logic [crcc_pkg::DATA_W-1:0]           req_src_offset,
   input  logic [crcc_pkg::DATA_W-1:0]           req_dst_offset,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [crcc_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_final_res
);
   import crcc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   crcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   crcc_dpath #(
      .MAX_DESTS  (MAX_DESTS),
      .MAX_RANGES (MAX_RANGES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_func       (req_func),
      .req_dest_index (req_dest_index),
      .req_dest_size  (req_dest_size),
      .req_length     (req_length),
      .req_src_offset (req_src_offset),
      .req_dst_offset (req_dst_offset),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_final_res  (rsp_final_res),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

/* hw/rtl/crcc_ctrl.sv */
// ----------------------------------------------------------------------------
// crcc_ctrl: sequencing state machine
// Accepts items, steps range checks and walks the cover scan.
// ----------------------------------------------------------------------------
module crcc_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic [crcc_pkg::FUNC_W-1:0]           req_func,
   output logic                                  req_ready,
   input  crcc_pkg::sts_type                     sts,
   output crcc_pkg::cmd_type                     cmd
);
   import crcc_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_CHK      = 6'b000010,
      S_SCAN_RD  = 6'b000100,
      S_SCAN_CMP = 6'b001000,
      S_DEST_RD  = 6'b010000,
      S_DEST_CMP = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      fire;

   assign req_ready = (state_ff == S_IDLE) && sts.rsp_free;
   assign fire      = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.fin_code = STAT_OK;
      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               case (func_type'(req_func))
                  FUNC_RANGE: begin
                     cmd.accept_range = 1'b1;
                     state_in = S_CHK;
                  end
                  FUNC_FINISH: begin
                     if (sts.fin_quick) begin
                        cmd.fin_quick = 1'b1;
                     end else begin
                        cmd.scan_init = 1'b1;
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: cmd.accept_simple = 1'b1;
               endcase
            end
         end
         S_CHK: begin
            cmd.range_done = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            cmd.scan_step = 1'b1;
            if (sts.match)       state_in = S_SCAN_RD;
            else if (sts.last_k) state_in = S_DEST_RD;
            else                 state_in = S_SCAN_RD;
         end
         S_DEST_RD: state_in = S_DEST_CMP;
         S_DEST_CMP: begin
            if (!sts.size_ok) begin
               cmd.fin_emit = 1'b1;
               cmd.fin_code = STAT_BAD_COVER;
               state_in = S_IDLE;
            end else if (sts.last_dest) begin
               cmd.fin_emit = 1'b1;
               cmd.fin_code = sts.all_used ? STAT_OK : STAT_BAD_COVER;
               state_in = S_IDLE;
            end else begin
               cmd.dest_next = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/crcc_dpath.sv */
// ----------------------------------------------------------------------------
// crcc_dpath: checker datapath
// Configuration registers, size table, range store, range checks, cover
// scan counters and the result register.
// ----------------------------------------------------------------------------
module crcc_dpath #(
   parameter int MAX_DESTS  = crcc_pkg::MAX_DESTS_DEF,
   parameter int MAX_RANGES = crcc_pkg::MAX_RANGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [crcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [crcc_pkg::DATA_W-1:0]           csr_wr_data,
   input  logic [crcc_pkg::FUNC_W-1:0]           req_func,
   input  logic [crcc_pkg::IDX_W-1:0]            req_dest_index,
   input  logic [crcc_pkg::DATA_W-1:0]           req_dest_size,
   input  logic [crcc_pkg::DATA_W-1:0]           req_length,
   input  logic [crcc_pkg::DATA_W-1:0]           req_src_offset,
   input  logic [crcc_pkg::DATA_W-1:0]           req_dst_offset,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [crcc_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_final_res,
   input  crcc_pkg::cmd_type                     cmd,
   output crcc_pkg::sts_type                     sts
);
   import crcc_pkg::*;

   localparam int CW  = $clog2(MAX_RANGES + 1);
   localparam int AW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int DAW = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
   localparam int EW  = 9;   // holds any destination index or MAX_DESTS

   // configuration
   logic [DATA_W-1:0] source_size_ff;
   logic [DCNT_W-1:0] dest_count_ff;
   logic [DCNT_W-1:0] active;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_size_ff <= '0;
         dest_count_ff  <= DCNT_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SOURCE_SIZE: source_size_ff <= csr_wr_data;
            CSR_DEST_COUNT:  dest_count_ff  <= csr_wr_data[DCNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign active = ({4'b0, dest_count_ff} > EW'(MAX_DESTS)) ? DCNT_W'(MAX_DESTS)
                                                           : dest_count_ff;

   // batch state and scan counters
   logic [CW-1:0]          total_ff, used_ff, k_ff;
   logic [STATUS_W-1:0]    first_error_ff;
   logic [DCNT_W-1:0]      d_ff;
   logic [DATA_W-1:0]      expect_ff;

   // size table, registered read
   logic [DATA_W-1:0] size_mem [MAX_DESTS];
   logic [DATA_W-1:0] size_rd_ff;
   logic [EW-1:0]     idx_ext, d_ext;
   logic [DAW-1:0]    size_addr;
   logic              idx_in_table;

   assign idx_ext      = {5'b0, req_dest_index};
   assign d_ext        = {4'b0, d_ff};
   assign idx_in_table = idx_ext < EW'(MAX_DESTS);
   assign size_addr    = cmd.accept_range ? idx_ext[DAW-1:0] : d_ext[DAW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept_simple && func_type'(req_func) == FUNC_LOAD && idx_in_table) begin
         size_mem[idx_ext[DAW-1:0]] <= req_dest_size;
      end
      size_rd_ff <= size_mem[size_addr];
   end

   // range operands, first check stage
   logic [IDX_W-1:0]  op_idx_ff;
   logic [DATA_W-1:0] op_dofs_ff, op_send_ff, op_dend_ff;
   logic              op_bad_idx_ff, op_zero_ff, op_ovf_ff;
   logic [DATA_W:0]   send_sum, dend_sum;

   assign send_sum = {1'b0, req_src_offset} + {1'b0, req_length};
   assign dend_sum = {1'b0, req_dst_offset} + {1'b0, req_length};

   always_ff @(posedge clock) begin
      if (cmd.accept_range) begin
         op_idx_ff     <= req_dest_index;
         op_dofs_ff    <= req_dst_offset;
         op_send_ff    <= send_sum[DATA_W-1:0];
         op_dend_ff    <= dend_sum[DATA_W-1:0];
         op_bad_idx_ff <= {1'b0, req_dest_index} >= active;
         op_zero_ff    <= (req_length == '0);
         op_ovf_ff     <= send_sum[DATA_W] | dend_sum[DATA_W];
      end
   end

   // second check stage
   status_type chk_code;
   logic       store_full;

   assign store_full = (total_ff == CW'(MAX_RANGES));

   always_comb begin
      if (op_bad_idx_ff)                                   chk_code = STAT_BAD_INDEX;
      else if (op_zero_ff)                                 chk_code = STAT_ZERO_LEN;
      else if (op_ovf_ff)                                  chk_code = STAT_OVERFLOW;
      else if (op_send_ff > source_size_ff || op_dend_ff > size_rd_ff)
                                                           chk_code = STAT_OOB;
      else if (store_full)                                 chk_code = STAT_FULL;
      else                                                 chk_code = STAT_OK;
   end

   // range store, registered read at the scan pointer
   logic [IDX_W-1:0]  st_dest_mem  [MAX_RANGES];
   logic [DATA_W-1:0] st_start_mem [MAX_RANGES];
   logic [DATA_W-1:0] st_end_mem   [MAX_RANGES];
   logic [IDX_W-1:0]  rd_dest_ff;
   logic [DATA_W-1:0] rd_start_ff, rd_end_ff;
   logic              store_wr;

   assign store_wr = cmd.range_done && (chk_code == STAT_OK);

   always_ff @(posedge clock) begin
      if (store_wr) begin
         st_dest_mem[total_ff[AW-1:0]]  <= op_idx_ff;
         st_start_mem[total_ff[AW-1:0]] <= op_dofs_ff;
         st_end_mem[total_ff[AW-1:0]]   <= op_dend_ff;
      end
      rd_dest_ff  <= st_dest_mem[k_ff[AW-1:0]];
      rd_start_ff <= st_start_mem[k_ff[AW-1:0]];
      rd_end_ff   <= st_end_mem[k_ff[AW-1:0]];
   end

   // scan status
   status_type quick_code;
   assign quick_code = (first_error_ff != '0) ? status_type'(first_error_ff) :
                       (total_ff == '0)       ? STAT_NO_RANGES : STAT_BAD_COVER;

   assign sts.rsp_free  = !rsp_valid || rsp_ready;
   assign sts.fin_quick = (first_error_ff != '0) || (total_ff == '0) || (active == '0);
   assign sts.match     = ({1'b0, rd_dest_ff} == d_ff) && (rd_start_ff == expect_ff);
   assign sts.last_k    = (k_ff == total_ff - CW'(1));
   assign sts.size_ok   = (expect_ff == size_rd_ff);
   assign sts.last_dest = (d_ff + DCNT_W'(1) == active);
   assign sts.all_used  = (used_ff == total_ff);

   // batch and scan registers
   logic batch_end;
   assign batch_end = cmd.fin_quick || cmd.fin_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= '0;
         first_error_ff <= '0;
      end else if (batch_end) begin
         total_ff       <= '0;
         first_error_ff <= '0;
      end else if (cmd.range_done) begin
         if (store_wr) begin
            total_ff <= total_ff + CW'(1);
         end else if (first_error_ff == '0) begin
            first_error_ff <= chk_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.scan_init || cmd.dest_next || (cmd.scan_step && sts.match)) begin
         k_ff <= '0;
      end else if (cmd.scan_step && !sts.last_k) begin
         k_ff <= k_ff + CW'(1);
      end
   end

   // clear the used count at scan start and at batch end
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.scan_init || batch_end) begin
         used_ff <= '0;
      end else if (cmd.scan_step && sts.match) begin
         used_ff <= used_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         d_ff      <= '0;
         expect_ff <= '0;
      end else if (cmd.dest_next) begin
         d_ff      <= d_ff + DCNT_W'(1);
         expect_ff <= '0;
      end else if (cmd.scan_step && sts.match) begin
         expect_ff <= rd_end_ff;
      end
   end

   // result register
   logic                rsp_valid_ff, rsp_final_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                produce;
   logic [STATUS_W-1:0] produce_code;
   logic                produce_final;

   assign produce = cmd.accept_simple || cmd.range_done || batch_end;

   always_comb begin
      produce_final = batch_end;
      if (cmd.fin_quick)        produce_code = quick_code;
      else if (cmd.fin_emit)    produce_code = cmd.fin_code;
      else if (cmd.range_done)  produce_code = chk_code;
      else if (func_type'(req_func) == FUNC_LOAD && !idx_in_table)
                                produce_code = STAT_BAD_INDEX;
      else                      produce_code = STAT_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         rsp_status_ff <= produce_code;
         rsp_final_ff  <= produce_final;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_final_res = rsp_final_ff;

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MAX_RANGES))
      else $error("range count beyond store depth");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= total_ff)
      else $error("cover scan used more ranges than stored");

   a_batch_clear: assert property (@(posedge clock) disable iff (reset)
      batch_end |=> (total_ff == '0) && (first_error_ff == '0))
      else $error("batch state not cleared after finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      produce |-> !rsp_valid_ff || rsp_ready)
      else $error("result overwritten before transfer");
`endif

endmodule
